>>> sv/iesc_pkg.sv
// Shared types, character codes and the character classifier for the
// infix expression syntax checker. No dependencies.
package iesc_pkg;

    typedef enum logic [2:0] {
        CL_DIGIT   = 3'd0,
        CL_DOT     = 3'd1,
        CL_LETTER  = 3'd2,
        CL_LBRACK  = 3'd3,
        CL_RBRACK  = 3'd4,
        CL_OPER    = 3'd5,
        CL_UNKNOWN = 3'd6
    } char_class_t;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_SYNTAX   = 4'd1,
        ST_NO_LEFT  = 4'd2,
        ST_BAD_NUM  = 4'd3,
        ST_NO_FRAC  = 4'd4,
        ST_BAD_OP   = 4'd5,
        ST_USELESS  = 4'd6,
        ST_NO_RIGHT = 4'd7,
        ST_TOO_DEEP = 4'd8
    } status_t;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    function automatic char_class_t class_of(input logic [7:0] c);
        char_class_t cls;
        if (c == CH_LPAREN) begin
            cls = CL_LBRACK;
        end else if (c == CH_RPAREN) begin
            cls = CL_RBRACK;
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                     c == CH_CARET || c == CH_BANG || c == CH_PERCENT) begin
            cls = CL_OPER;
        end else if (c == CH_DOT) begin
            cls = CL_DOT;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            cls = CL_DIGIT;
        end else if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                     (c >= CH_LOWER_A && c <= CH_LOWER_Z)) begin
            cls = CL_LETTER;
        end else begin
            cls = CL_UNKNOWN;
        end
        return cls;
    endfunction

endpackage

>>> sv/infix_expression_syntax_checker.sv
// Infix expression syntax checker, top level: input register, per-character
// checks with held expression state, result register. Depends on iesc_pkg.
//
// Usage: characters arrive on the s_ channel (s_ch, s_is_end) with
// valid/ready, one transfer per character. Every transfer gives exactly one
// result on the m_ channel: m_status is the first error held so far (0 if
// none) and m_final_res is 0 for a character; for an end marker m_status is
// the verdict for the whole expression, m_final_res is 1, and the expression
// state returns to its start so the next character begins a new expression.
// A character taken into the input register is checked there, and its result
// is written into the result register, which drives m_valid. Throughput is one
// character per clock while m_ready stays high; the bracket depth counter and
// the class/error registers are updated as each character is checked, so no
// character waits on the one before it.
// Reset (aresetn low, synchronous) empties both registers and returns to the
// start of an expression. When the receiver stalls, the result is held in the
// result register, one more character waits in the input register, and
// s_ready falls until m_ready returns.
// Bracket depth is counted up to MAX_DEPTH; an opening bracket beyond it
// reports the too-deep error.
module infix_expression_syntax_checker
    import iesc_pkg::*;
#(
    parameter int MAX_DEPTH = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_is_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_status,
    output logic       m_final_res
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_end_reg;

    // expression state
    char_class_t        prev_class_reg, prev_class_next;
    logic               prev_bang_reg, prev_bang_next;
    logic               at_first_reg, at_first_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    status_t            sticky_reg, sticky_next;

    // result register
    logic    m_valid_reg;
    status_t m_status_reg, status_next;
    logic    m_final_reg;

    logic        advance;
    char_class_t cls;
    status_t     char_err;
    status_t     verdict;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_final_res = m_final_reg;

    assign cls = class_of(in_ch_reg);

    // error for this character in priority order
    always_comb begin
        char_err = ST_OK;
        if (cls == CL_UNKNOWN) begin
            char_err = ST_SYNTAX;
        end else if (cls == CL_LBRACK && depth_reg == DEPTH_MAX) begin
            char_err = ST_TOO_DEEP;
        end else if (cls == CL_RBRACK && depth_reg == '0) begin
            char_err = ST_NO_LEFT;
        end else if (at_first_reg &&
                     ((cls == CL_OPER && in_ch_reg != CH_MINUS) || cls == CL_DOT)) begin
            char_err = ST_SYNTAX;
        end else begin
            case (prev_class_reg)
                CL_DIGIT: begin
                    if (cls != CL_DIGIT && cls != CL_DOT && cls != CL_OPER &&
                        cls != CL_RBRACK) begin
                        char_err = ST_BAD_NUM;
                    end
                end
                CL_DOT: begin
                    if (cls != CL_DIGIT) begin
                        char_err = ST_NO_FRAC;
                    end
                end
                CL_OPER: begin
                    if ((cls == CL_RBRACK || cls == CL_OPER) && !prev_bang_reg) begin
                        char_err = ST_BAD_OP;
                    end
                end
                CL_LBRACK: begin
                    if (cls == CL_OPER && in_ch_reg != CH_MINUS) begin
                        char_err = ST_BAD_OP;
                    end
                end
                default: begin
                    char_err = ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        verdict = sticky_reg;
        if (sticky_reg == ST_OK) begin
            if (prev_class_reg == CL_OPER && !prev_bang_reg) begin
                verdict = ST_USELESS;
            end else if (depth_reg != '0) begin
                verdict = ST_NO_RIGHT;
            end
        end
    end

    always_comb begin
        prev_class_next = prev_class_reg;
        prev_bang_next  = prev_bang_reg;
        at_first_next   = at_first_reg;
        depth_next      = depth_reg;
        sticky_next     = sticky_reg;
        status_next     = sticky_reg;
        if (in_end_reg) begin
            status_next     = verdict;
            prev_class_next = CL_UNKNOWN;
            prev_bang_next  = 1'b0;
            at_first_next   = 1'b1;
            depth_next      = '0;
            sticky_next     = ST_OK;
        end else if (sticky_reg == ST_OK) begin
            if (char_err != ST_OK) begin
                sticky_next = char_err;
                status_next = char_err;
            end else begin
                prev_class_next = cls;
                prev_bang_next  = (in_ch_reg == CH_BANG);
                at_first_next   = 1'b0;
                if (cls == CL_LBRACK) begin
                    depth_next = depth_reg + 1'b1;
                end else if (cls == CL_RBRACK) begin
                    depth_next = depth_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            prev_class_reg <= CL_UNKNOWN;
            prev_bang_reg  <= 1'b0;
            at_first_reg   <= 1'b1;
            depth_reg      <= '0;
            sticky_reg     <= ST_OK;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg    <= 1'b1;
                prev_class_reg <= prev_class_next;
                prev_bang_reg  <= prev_bang_next;
                at_first_reg   <= at_first_next;
                depth_reg      <= depth_next;
                sticky_reg     <= sticky_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg  <= s_ch;
            in_end_reg <= s_is_end;
        end
        if (advance) begin
            m_status_reg <= status_next;
            m_final_reg  <= in_end_reg;
        end
    end

    // an end marker leaves the block at the start of a fresh expression
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_end_reg |=> depth_reg == '0 && at_first_reg && sticky_reg == ST_OK)
        else $error("state not cleared after end marker");

    // a held error only changes at an end marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        sticky_reg != ST_OK && !(advance && in_end_reg) |=> sticky_reg == $past(sticky_reg))
        else $error("held error changed before end marker");

    // depth counter never passes its limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_MAX)
        else $error("bracket depth above limit");

    // a character result reports the held error
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_end_reg |=> m_status_reg == sticky_reg && !m_final_reg)
        else $error("character result differs from held error");

endmodule
